>>> design/kmst_pkg.sv
// Shared constants and types for the minimum spanning tree block.
package kmst_pkg;

  localparam int DEF_MAX_EDGES    = 64;
  localparam int DEF_MAX_VERTICES = 32;
  localparam int VTX_W            = 5;
  localparam int COST_W           = 16;
  localparam int TOTAL_W          = 21;
  localparam int CFG_W            = 6;
  localparam logic [CFG_W-1:0] VCOUNT_RESET = CFG_W'(32);
  localparam logic [2:0] ADDR_VCOUNT = 3'd0;

  // One stored edge as kept in the edge store
  typedef struct packed {
    logic [VTX_W-1:0]  end_a;
    logic [VTX_W-1:0]  end_b;
    logic [COST_W-1:0] weight;
  } edge_t;

  localparam int EDGE_W = $bits(edge_t);

endpackage

>>> design/kmst_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
module kmst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> design/kruskal_min_spanning_tree.sv
// Top level: edge loading, stable min-selection walk and union-find tree build.
//
//  channel | ports                          | handshake
//  --------+--------------------------------+----------------------------------
//  input   | in_vertex_a/b, in_edge_cost,   | taken when start && !busy
//          | in_last_edge                   |
//  result  | out_kind .. out_last           | out_valid high for one cycle
//  config  | psel penable pwrite paddr ...  | write at psel&penable&pwrite
//
// Edges load while idle, one per accepted start. After the marked last edge, a
// clearing pass over all MAX_VERTICES entries resets the parent table. Each
// edge picked by the walk passes S_NEXT, a full scan of the edge store
// through its single read port (S_SCAN), a range check (S_PICK), a root find
// per end that climbs the parent table one step per read (S_FIND, S_FWAIT)
// and, when the roots differ, a link (S_LINK).
// Reset is synchronous, active low. The receiver cannot stall results.
module kruskal_min_spanning_tree #(
  parameter int MAX_EDGES    = kmst_pkg::DEF_MAX_EDGES,
  parameter int MAX_VERTICES = kmst_pkg::DEF_MAX_VERTICES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [kmst_pkg::VTX_W-1:0]        in_vertex_a,
  input  logic [kmst_pkg::VTX_W-1:0]        in_vertex_b,
  input  logic signed [kmst_pkg::COST_W-1:0] in_edge_cost,
  input  logic                              in_last_edge,
  output logic                              out_valid,
  output logic                              out_kind,
  output logic [kmst_pkg::VTX_W-1:0]        out_tree_vertex_a,
  output logic [kmst_pkg::VTX_W-1:0]        out_tree_vertex_b,
  output logic signed [kmst_pkg::COST_W-1:0] out_tree_cost,
  output logic signed [kmst_pkg::TOTAL_W-1:0] out_total_cost,
  output logic                              out_spanning,
  output logic                              out_overflow,
  output logic                              out_last,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int IW  = $clog2(MAX_EDGES);
  localparam int CW  = IW + 1;
  localparam int PW  = $clog2(MAX_VERTICES);
  localparam int VW  = kmst_pkg::VTX_W;
  localparam int KW  = kmst_pkg::COST_W + IW;
  localparam int TW  = kmst_pkg::TOTAL_W;
  localparam int FW  = kmst_pkg::CFG_W;
  localparam logic signed [TW:0] TOT_MAX = (TW+1)'((1 << (TW-1)) - 1);
  localparam logic signed [TW:0] TOT_MIN = -(TW+1)'(1 << (TW-1));

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_NEXT, S_SCAN, S_PICK, S_FIND, S_FWAIT, S_LINK, S_SUM
  } state_t;

  state_t state_r, state_nxt;

  logic [FW-1:0]  vcount_r;
  logic [CW-1:0]  count_r, count_nxt;
  logic           drop_r, drop_nxt;
  logic [PW-1:0]  clr_r, clr_nxt;
  logic [CW-1:0]  si_r, si_nxt;
  logic           pend_r, pend_nxt;
  logic [IW-1:0]  pidx_r, pidx_nxt;
  logic           best_v_r, best_v_nxt;
  logic [KW-1:0]  best_key_r, best_key_nxt;
  kmst_pkg::edge_t best_e_r, best_e_nxt;
  logic           have_prev_r, have_prev_nxt;
  logic [KW-1:0]  prev_key_r, prev_key_nxt;
  logic [CW-1:0]  picks_r, picks_nxt;
  logic [FW-1:0]  found_r, found_nxt;
  logic           phase_b_r, phase_b_nxt;
  logic [PW-1:0]  cur_r, cur_nxt;
  logic [PW-1:0]  ra_r, ra_nxt;
  logic signed [TW-1:0] total_r, total_nxt;

  logic           ov_r, ov_nxt;
  logic           okind_r, okind_nxt;
  logic [VW-1:0]  oa_r, oa_nxt, ob_r, ob_nxt;
  logic [kmst_pkg::COST_W-1:0] oc_r, oc_nxt;
  logic           ospan_r, ospan_nxt, oovf_r, oovf_nxt, olast_r, olast_nxt;

  // memory ports
  logic            e_we;
  kmst_pkg::edge_t e_wdata, e_rdata;
  logic [IW-1:0]   e_raddr;
  logic            p_we;
  logic [PW-1:0]   p_waddr, p_wdata, p_raddr, p_rdata;

  logic [FW-1:0]   nv;
  logic [FW-1:0]   target;
  logic            accept;
  logic [KW-1:0]   cand_key;
  logic            cand_ok;
  logic signed [TW:0] sum_w;

  kmst_ram #(.WIDTH(kmst_pkg::EDGE_W), .DEPTH(MAX_EDGES)) u_edges (
    .clk(clk), .we(e_we), .waddr(count_r[IW-1:0]), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  kmst_ram #(.WIDTH(PW), .DEPTH(MAX_VERTICES)) u_parent (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign pready  = 1'b1;
  assign prdata  = (paddr == kmst_pkg::ADDR_VCOUNT) ? 32'(vcount_r) : 32'd0;

  assign e_we    = accept && (count_r < CW'(MAX_EDGES));
  assign e_wdata = '{end_a: in_vertex_a, end_b: in_vertex_b, weight: in_edge_cost};

  // clip the vertex count into range
  always_comb begin
    if (vcount_r == '0) nv = FW'(1);
    else if (vcount_r > FW'(MAX_VERTICES)) nv = FW'(MAX_VERTICES);
    else nv = vcount_r;
  end
  assign target = nv - FW'(1);

  // order key: signed weight made monotone, then arrival index
  assign cand_key = {~e_rdata.weight[kmst_pkg::COST_W-1],
                     e_rdata.weight[kmst_pkg::COST_W-2:0], pidx_r};
  assign cand_ok  = pend_r && (!have_prev_r || cand_key > prev_key_r) &&
                    (!best_v_r || cand_key < best_key_r);

  assign sum_w = (TW+1)'(total_r) + (TW+1)'($signed(best_e_r.weight));

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= kmst_pkg::VCOUNT_RESET;
    end else if (psel && penable && pwrite && paddr == kmst_pkg::ADDR_VCOUNT) begin
      vcount_r <= pwdata[FW-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;     drop_nxt = drop_r;
    clr_nxt = clr_r;         si_nxt = si_r;
    pend_nxt = 1'b0;         pidx_nxt = pidx_r;
    best_v_nxt = best_v_r;   best_key_nxt = best_key_r;  best_e_nxt = best_e_r;
    have_prev_nxt = have_prev_r; prev_key_nxt = prev_key_r;
    picks_nxt = picks_r;     found_nxt = found_r;
    phase_b_nxt = phase_b_r; cur_nxt = cur_r;  ra_nxt = ra_r;
    total_nxt = total_r;
    ov_nxt = 1'b0;           okind_nxt = okind_r;
    oa_nxt = oa_r;  ob_nxt = ob_r;  oc_nxt = oc_r;
    ospan_nxt = ospan_r;  oovf_nxt = oovf_r;  olast_nxt = olast_r;
    e_raddr = si_r[IW-1:0];
    p_we = 1'b0;  p_waddr = clr_r;  p_wdata = clr_r;
    p_raddr = cur_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (e_we) count_nxt = count_r + CW'(1);
          else      drop_nxt = 1'b1;
          if (in_last_edge) begin
            clr_nxt = '0;
            state_nxt = S_CLEAR;
          end
        end
      end
      S_CLEAR: begin
        // reset every vertex to its own root
        p_we = 1'b1;
        clr_nxt = clr_r + PW'(1);
        if (clr_r == PW'(MAX_VERTICES - 1)) begin
          picks_nxt = '0;  found_nxt = '0;  total_nxt = '0;
          have_prev_nxt = 1'b0;
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (picks_r == count_r || found_r == target) begin
          state_nxt = S_SUM;
        end else begin
          si_nxt = '0;  best_v_nxt = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // stream the store and keep the least key above the previous pick
        if (si_r < count_r) begin
          pend_nxt = 1'b1;
          pidx_nxt = si_r[IW-1:0];
          si_nxt = si_r + CW'(1);
        end
        if (cand_ok) begin
          best_v_nxt = 1'b1;  best_key_nxt = cand_key;  best_e_nxt = e_rdata;
        end
        if (si_r >= count_r && !pend_r) state_nxt = S_PICK;
      end
      S_PICK: begin
        have_prev_nxt = 1'b1;
        prev_key_nxt = best_key_r;
        picks_nxt = picks_r + CW'(1);
        if (FW'(best_e_r.end_a) >= nv || FW'(best_e_r.end_b) >= nv) begin
          state_nxt = S_NEXT;
        end else begin
          cur_nxt = PW'(best_e_r.end_a);
          phase_b_nxt = 1'b0;
          state_nxt = S_FIND;
        end
      end
      S_FIND: begin
        state_nxt = S_FWAIT;
      end
      S_FWAIT: begin
        // climb the parent chain one step per read
        if (p_rdata != cur_r) begin
          cur_nxt = p_rdata;
          p_raddr = p_rdata;
        end else if (!phase_b_r) begin
          ra_nxt = cur_r;
          cur_nxt = PW'(best_e_r.end_b);
          phase_b_nxt = 1'b1;
          state_nxt = S_FIND;
        end else if (ra_r == cur_r) begin
          state_nxt = S_NEXT;
        end else begin
          state_nxt = S_LINK;
        end
      end
      S_LINK: begin
        // link first root under second, emit the tree edge
        p_we = 1'b1;  p_waddr = ra_r;  p_wdata = cur_r;
        found_nxt = found_r + FW'(1);
        if (sum_w > TOT_MAX)      total_nxt = TOT_MAX[TW-1:0];
        else if (sum_w < TOT_MIN) total_nxt = TOT_MIN[TW-1:0];
        else                      total_nxt = sum_w[TW-1:0];
        ov_nxt = 1'b1;  okind_nxt = 1'b0;
        oa_nxt = best_e_r.end_a;  ob_nxt = best_e_r.end_b;
        oc_nxt = best_e_r.weight;
        ospan_nxt = 1'b0;  oovf_nxt = 1'b0;  olast_nxt = 1'b0;
        state_nxt = S_NEXT;
      end
      S_SUM: begin
        ov_nxt = 1'b1;  okind_nxt = 1'b1;
        oa_nxt = '0;  ob_nxt = '0;  oc_nxt = '0;
        ospan_nxt = (found_r == target);
        oovf_nxt = drop_r;  olast_nxt = 1'b1;
        count_nxt = '0;  drop_nxt = 1'b0;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      drop_r  <= 1'b0;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      drop_r  <= drop_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    clr_r <= clr_nxt;          si_r <= si_nxt;           pidx_r <= pidx_nxt;
    best_v_r <= best_v_nxt;    best_key_r <= best_key_nxt; best_e_r <= best_e_nxt;
    have_prev_r <= have_prev_nxt; prev_key_r <= prev_key_nxt;
    picks_r <= picks_nxt;      found_r <= found_nxt;
    phase_b_r <= phase_b_nxt;  cur_r <= cur_nxt;          ra_r <= ra_nxt;
    total_r <= total_nxt;
    okind_r <= okind_nxt;  oa_r <= oa_nxt;  ob_r <= ob_nxt;  oc_r <= oc_nxt;
    ospan_r <= ospan_nxt;  oovf_r <= oovf_nxt;  olast_r <= olast_nxt;
  end

  assign out_valid         = ov_r;
  assign out_kind          = okind_r;
  assign out_tree_vertex_a = oa_r;
  assign out_tree_vertex_b = ob_r;
  assign out_tree_cost     = oc_r;
  assign out_total_cost    = total_r;
  assign out_spanning      = ospan_r;
  assign out_overflow      = oovf_r;
  assign out_last          = olast_r;

  // checks
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_EDGES))
    else $error("edge count beyond store capacity");

  a_last_run: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last_edge |=> busy)
    else $error("last edge did not start a run");

  a_tree_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_kind |-> busy)
    else $error("tree edge emitted outside a run");

  a_sum_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy && count_r == '0)
    else $error("summary not at end of run");

endmodule
